### rtl/stt_pkg.sv
// Shared types, token kind codes, lexer modes and character helpers for the
// source text tokenizer. No dependencies.
package stt_pkg;

    localparam int OFFSET_BITS_DEF = 20;
    localparam int LINE_BITS_DEF   = 20;
    localparam int MAX_RES         = 4;

    // Token kind codes
    localparam logic [5:0] K_LPAREN   = 6'd0;
    localparam logic [5:0] K_RPAREN   = 6'd1;
    localparam logic [5:0] K_LBRACE   = 6'd2;
    localparam logic [5:0] K_RBRACE   = 6'd3;
    localparam logic [5:0] K_LBRACK   = 6'd4;
    localparam logic [5:0] K_RBRACK   = 6'd5;
    localparam logic [5:0] K_COMMA    = 6'd6;
    localparam logic [5:0] K_DOT      = 6'd7;
    localparam logic [5:0] K_MINUS    = 6'd8;
    localparam logic [5:0] K_PLUS     = 6'd10;
    localparam logic [5:0] K_SEMI     = 6'd12;
    localparam logic [5:0] K_STAR     = 6'd13;
    localparam logic [5:0] K_CARET    = 6'd14;
    localparam logic [5:0] K_PERCENT  = 6'd15;
    localparam logic [5:0] K_BSLASH   = 6'd16;
    localparam logic [5:0] K_BANG     = 6'd17;
    localparam logic [5:0] K_EQUAL    = 6'd19;
    localparam logic [5:0] K_LESS     = 6'd21;
    localparam logic [5:0] K_GREATER  = 6'd23;
    localparam logic [5:0] K_SLASH    = 6'd25;
    localparam logic [5:0] K_STRING   = 6'd26;
    localparam logic [5:0] K_INTEGER  = 6'd27;
    localparam logic [5:0] K_DECIMAL  = 6'd28;
    localparam logic [5:0] K_IDENT    = 6'd29;
    localparam logic [5:0] K_KEYWORD0 = 6'd30;
    localparam logic [5:0] K_END      = 6'd46;
    localparam logic [5:0] K_BADCHAR  = 6'd47;
    localparam logic [5:0] K_UNTERM   = 6'd48;
    localparam logic [5:0] K_NONE     = 6'h3F;

    // Character codes
    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_LESS  = 8'h3C;
    localparam logic [7:0] C_EQUAL = 8'h3D;
    localparam logic [7:0] C_GREAT = 8'h3E;
    localparam logic [7:0] C_UNDER = 8'h5F;

    typedef enum logic [3:0] {
        M_IDLE,
        M_OP2,
        M_SLASH,
        M_LINECMT,
        M_BLOCK,
        M_BLOCKSTAR,
        M_STRING,
        M_INT,
        M_INTDOT,
        M_FRAC,
        M_IDENT
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] start;
        logic [19:0] len;
        logic [19:0] line;
        logic [30:0] ival;
        logic        ovf;
    } tok_t;

    localparam logic [47:0] KEYWORDS [16] = '{
        48'h0000_00616e64, 48'h0063_6c617373, 48'h0000_656c7365, 48'h0066_616c7365,
        48'h0000_00666f72, 48'h0000_0066756e, 48'h0000_00006966, 48'h0000_006e696c,
        48'h0000_00006f72, 48'h0070_72696e74, 48'h7265_7475726e, 48'h0073_75706572,
        48'h0000_74686973, 48'h0000_74727565, 48'h0000_00766172, 48'h0077_68696c65
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == C_UNDER);
    endfunction

    // One-byte operator kind, K_NONE when the byte is no such operator
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h2C:   k = K_COMMA;
            C_DOT:   k = K_DOT;
            8'h3B:   k = K_SEMI;
            C_STAR:  k = K_STAR;
            8'h5E:   k = K_CARET;
            8'h25:   k = K_PERCENT;
            8'h5C:   k = K_BSLASH;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // One-byte kind of a possible two-byte operator; the two-byte kind is one more
    function automatic logic [5:0] pair_kind(input logic [7:0] p);
        logic [5:0] k;
        case (p)
            C_MINUS: k = K_MINUS;
            C_PLUS:  k = K_PLUS;
            C_BANG:  k = K_BANG;
            C_EQUAL: k = K_EQUAL;
            C_LESS:  k = K_LESS;
            default: k = K_GREATER;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] pair_second(input logic [7:0] p);
        logic [7:0] s;
        case (p)
            C_MINUS: s = C_MINUS;
            C_PLUS:  s = C_PLUS;
            default: s = C_EQUAL;
        endcase
        return s;
    endfunction

    // Parallel match of the packed buffer against the keyword table
    function automatic logic [5:0] keyword_kind(input logic [47:0] kb);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 0; i < 16; i++) begin
            if (kb == KEYWORDS[i]) begin
                k = K_KEYWORD0 + 6'(i);
            end
        end
        return k;
    endfunction

endpackage

### rtl/source_text_tokenizer_core.sv
// Source text tokenizer: one source byte in per beat, tokens out per beat.
// The first token of a byte is registered and appears in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one token and the
// token output does not stall; a byte that yields N tokens (N up to 4) stalls the source
// side until the single token output port drains the last token from the result bank.
// Reset (rst_n low, asynchronous): lexer idle, offset 0, line 1, no pending tokens.
module source_text_tokenizer_core #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  ch,
    input  logic        final_byte,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [5:0]  kind,
    output logic [19:0] start_offset,
    output logic [19:0] lexeme_length,
    output logic [19:0] line_number,
    output logic [30:0] int_value,
    output logic        int_overflow,
    output logic        last_of_run
);

    stt_pkg::tok_t res [stt_pkg::MAX_RES];
    stt_pkg::tok_t tok;
    logic [2:0]    res_cnt;
    logic          src_take;

    assign src_take = src_valid && !src_stall;

    stt_scan #(
        .OFFSET_BITS(OFFSET_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (src_take),
        .ch        (ch),
        .final_byte(final_byte),
        .res       (res),
        .res_cnt   (res_cnt)
    );

    stt_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (src_take),
        .res_in   (res),
        .cnt_in   (res_cnt),
        .out_stall(tok_stall),
        .out_valid(tok_valid),
        .tok      (tok),
        .last     (last_of_run),
        .hold     (src_stall)
    );

    // Unpack the token beat onto the ports
    assign kind          = tok.kind;
    assign start_offset  = tok.start;
    assign lexeme_length = tok.len;
    assign line_number   = tok.line;
    assign int_value     = tok.ival;
    assign int_overflow  = tok.ovf;

endmodule

### rtl/stt_scan.sv
// Lexer state registers and the single-pass next-state and token logic.
// Depends on stt_pkg.
module stt_scan #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic [7:0]   ch,
    input  logic         final_byte,
    output stt_pkg::tok_t res [stt_pkg::MAX_RES],
    output logic [2:0]   res_cnt
);

    stt_pkg::mode_t         mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] ts_reg, ts_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [7:0]             pc_reg, pc_next;
    logic [47:0]            kb_reg, kb_next;
    logic [30:0]            acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;

    logic [OFFSET_BITS-1:0] pos, endp, len;
    logic [35:0]            wide;
    logic [5:0]             sk, k1;
    logic                   do_start;
    logic [2:0]             n;

    function automatic logic [19:0] off20(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[19:0];
    endfunction

    function automatic stt_pkg::tok_t mk(input logic [5:0] kind,
                                          input logic [OFFSET_BITS-1:0] start,
                                          input logic [OFFSET_BITS-1:0] ln,
                                          input logic [LINE_BITS-1:0] line,
                                          input logic [30:0] ival,
                                          input logic ovf);
        stt_pkg::tok_t t;
        logic [31:0] w;
        w = 32'(line);
        t.kind  = kind;
        t.start = off20(start);
        t.len   = off20(ln);
        t.line  = w[19:0];
        t.ival  = ival;
        t.ovf   = ovf;
        return t;
    endfunction

    // Scan one byte, then close the source when it is the final byte
    always_comb
    begin
        mode_next = mode_reg;
        ts_next   = ts_reg;
        pc_next   = pc_reg;
        kb_next   = kb_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        line_next = line_reg;
        pos       = off_reg;
        endp      = off_reg + OFFSET_BITS'(1);
        off_next  = endp;
        len       = '0;
        wide      = '0;
        sk        = stt_pkg::K_NONE;
        k1        = stt_pkg::pair_kind(pc_reg);
        do_start  = 1'b0;
        n         = 3'd0;
        for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
            res[i] = '0;
        end

        case (mode_reg)
            stt_pkg::M_OP2:
            begin
                mode_next = stt_pkg::M_IDLE;
                if (ch == stt_pkg::pair_second(pc_reg)) begin
                    res[n[1:0]] = mk(k1 + 6'd1, ts_reg, OFFSET_BITS'(2), line_next, '0, 1'b0);
                    n = n + 3'd1;
                end else begin
                    res[n[1:0]] = mk(k1, ts_reg, OFFSET_BITS'(1), line_next, '0, 1'b0);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            stt_pkg::M_SLASH:
            begin
                if (ch == stt_pkg::C_SLASH) begin
                    mode_next = stt_pkg::M_LINECMT;
                end else if (ch == stt_pkg::C_STAR) begin
                    mode_next = stt_pkg::M_BLOCK;
                end else begin
                    res[n[1:0]] = mk(stt_pkg::K_SLASH, ts_reg, OFFSET_BITS'(1), line_next,
                                     '0, 1'b0);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            stt_pkg::M_LINECMT:
            begin
                if (ch == stt_pkg::C_LF) begin
                    mode_next = stt_pkg::M_IDLE;
                    if (line_next != '1) line_next = line_next + LINE_BITS'(1);
                end
            end
            stt_pkg::M_BLOCK:
            begin
                if (ch == stt_pkg::C_STAR) begin
                    mode_next = stt_pkg::M_BLOCKSTAR;
                end else if (ch == stt_pkg::C_LF) begin
                    if (line_next != '1) line_next = line_next + LINE_BITS'(1);
                end
            end
            stt_pkg::M_BLOCKSTAR:
            begin
                if (ch == stt_pkg::C_SLASH) begin
                    mode_next = stt_pkg::M_IDLE;
                end else if (ch != stt_pkg::C_STAR) begin
                    mode_next = stt_pkg::M_BLOCK;
                    if (ch == stt_pkg::C_LF && line_next != '1) begin
                        line_next = line_next + LINE_BITS'(1);
                    end
                end
            end
            stt_pkg::M_STRING:
            begin
                if (ch == stt_pkg::C_QUOTE) begin
                    res[n[1:0]] = mk(stt_pkg::K_STRING, ts_reg, endp - ts_reg, line_next,
                                     '0, 1'b0);
                    n = n + 3'd1;
                    mode_next = stt_pkg::M_IDLE;
                end else if (ch == stt_pkg::C_LF) begin
                    if (line_next != '1) line_next = line_next + LINE_BITS'(1);
                end
            end
            stt_pkg::M_INT:
            begin
                if (stt_pkg::is_digit(ch)) begin
                    // Multiply by ten with shifts, saturate at 2^31-1
                    wide = ({5'd0, acc_reg} << 3) + ({5'd0, acc_reg} << 1)
                         + {32'd0, ch[3:0]};
                    if (wide > 36'h07FFF_FFFF) begin
                        acc_next = '1;
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = wide[30:0];
                    end
                end else if (ch == stt_pkg::C_DOT) begin
                    mode_next = stt_pkg::M_INTDOT;
                end else begin
                    res[n[1:0]] = mk(stt_pkg::K_INTEGER, ts_reg, pos - ts_reg, line_next,
                                     acc_reg, ovf_reg);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            stt_pkg::M_INTDOT:
            begin
                if (stt_pkg::is_digit(ch)) begin
                    mode_next = stt_pkg::M_FRAC;
                end else begin
                    res[n[1:0]] = mk(stt_pkg::K_INTEGER, ts_reg,
                                     pos - OFFSET_BITS'(1) - ts_reg, line_next,
                                     acc_reg, ovf_reg);
                    n = n + 3'd1;
                    res[n[1:0]] = mk(stt_pkg::K_DOT, pos - OFFSET_BITS'(1), OFFSET_BITS'(1),
                                     line_next, '0, 1'b0);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            stt_pkg::M_FRAC:
            begin
                if (!stt_pkg::is_digit(ch)) begin
                    res[n[1:0]] = mk(stt_pkg::K_DECIMAL, ts_reg, pos - ts_reg, line_next,
                                     '0, 1'b0);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            stt_pkg::M_IDENT:
            begin
                if (stt_pkg::is_alpha(ch) || stt_pkg::is_digit(ch)) begin
                    kb_next = {kb_reg[39:0], ch};
                end else begin
                    len = pos - ts_reg;
                    res[n[1:0]] = mk((len > OFFSET_BITS'(6)) ? stt_pkg::K_IDENT
                                     : stt_pkg::keyword_kind(kb_reg),
                                     ts_reg, len, line_next, '0, 1'b0);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        // Start a new lexeme at this byte
        if (do_start) begin
            ts_next   = pos;
            mode_next = stt_pkg::M_IDLE;
            sk        = stt_pkg::single_kind(ch);
            if (sk != stt_pkg::K_NONE) begin
                res[n[1:0]] = mk(sk, pos, OFFSET_BITS'(1), line_next, '0, 1'b0);
                n = n + 3'd1;
            end else if (ch inside {stt_pkg::C_MINUS, stt_pkg::C_PLUS, stt_pkg::C_BANG,
                                    stt_pkg::C_EQUAL, stt_pkg::C_LESS, stt_pkg::C_GREAT}) begin
                mode_next = stt_pkg::M_OP2;
                pc_next   = ch;
            end else if (ch == stt_pkg::C_SLASH) begin
                mode_next = stt_pkg::M_SLASH;
            end else if (ch inside {stt_pkg::C_SPACE, stt_pkg::C_NUL, stt_pkg::C_CR,
                                    stt_pkg::C_TAB}) begin
                mode_next = stt_pkg::M_IDLE;
            end else if (ch == stt_pkg::C_LF) begin
                if (line_next != '1) line_next = line_next + LINE_BITS'(1);
            end else if (ch == stt_pkg::C_QUOTE) begin
                mode_next = stt_pkg::M_STRING;
            end else if (stt_pkg::is_digit(ch)) begin
                mode_next = stt_pkg::M_INT;
                acc_next  = {27'd0, ch[3:0]};
                ovf_next  = 1'b0;
            end else if (stt_pkg::is_alpha(ch)) begin
                mode_next = stt_pkg::M_IDENT;
                kb_next   = {40'd0, ch};
            end else begin
                res[n[1:0]] = mk(stt_pkg::K_BADCHAR, pos, OFFSET_BITS'(1), line_next,
                                 '0, 1'b0);
                n = n + 3'd1;
            end
        end

        // Close the source: flush the open lexeme, add the end token, reset
        if (final_byte) begin
            len = endp - ts_next;
            case (mode_next)
                stt_pkg::M_OP2:
                begin
                    res[n[1:0]] = mk(stt_pkg::pair_kind(pc_next), ts_next, OFFSET_BITS'(1),
                                     line_next, '0, 1'b0);
                    n = n + 3'd1;
                end
                stt_pkg::M_SLASH:
                begin
                    res[n[1:0]] = mk(stt_pkg::K_SLASH, ts_next, OFFSET_BITS'(1), line_next,
                                     '0, 1'b0);
                    n = n + 3'd1;
                end
                stt_pkg::M_STRING:
                begin
                    res[n[1:0]] = mk(stt_pkg::K_UNTERM, ts_next, len, line_next, '0, 1'b0);
                    n = n + 3'd1;
                end
                stt_pkg::M_INT:
                begin
                    res[n[1:0]] = mk(stt_pkg::K_INTEGER, ts_next, len, line_next,
                                     acc_next, ovf_next);
                    n = n + 3'd1;
                end
                stt_pkg::M_INTDOT:
                begin
                    res[n[1:0]] = mk(stt_pkg::K_INTEGER, ts_next, len - OFFSET_BITS'(1),
                                     line_next, acc_next, ovf_next);
                    n = n + 3'd1;
                    res[n[1:0]] = mk(stt_pkg::K_DOT, pos, OFFSET_BITS'(1), line_next,
                                     '0, 1'b0);
                    n = n + 3'd1;
                end
                stt_pkg::M_FRAC:
                begin
                    res[n[1:0]] = mk(stt_pkg::K_DECIMAL, ts_next, len, line_next, '0, 1'b0);
                    n = n + 3'd1;
                end
                stt_pkg::M_IDENT:
                begin
                    res[n[1:0]] = mk((len > OFFSET_BITS'(6)) ? stt_pkg::K_IDENT
                                     : stt_pkg::keyword_kind(kb_next),
                                     ts_next, len, line_next, '0, 1'b0);
                    n = n + 3'd1;
                end
                default:
                begin
                    n = n;
                end
            endcase
            if (n < 3'd4) begin
                res[n[1:0]] = mk(stt_pkg::K_END, endp, '0, line_next, '0, 1'b0);
                n = n + 3'd1;
            end
            mode_next = stt_pkg::M_IDLE;
            ts_next   = '0;
            off_next  = '0;
            line_next = LINE_BITS'(1);
            pc_next   = '0;
            kb_next   = '0;
            acc_next  = '0;
            ovf_next  = 1'b0;
        end
        res_cnt = n;
    end

    // Advance lexer state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= stt_pkg::M_IDLE;
            ts_reg   <= '0;
            off_reg  <= '0;
            line_reg <= LINE_BITS'(1);
            pc_reg   <= '0;
            kb_reg   <= '0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (take) begin
            mode_reg <= mode_next;
            ts_reg   <= ts_next;
            off_reg  <= off_next;
            line_reg <= line_next;
            pc_reg   <= pc_next;
            kb_reg   <= kb_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

### rtl/stt_outq.sv
// Result register bank: holds up to four tokens of one byte and hands them
// out one beat per cycle while the output does not stall. Depends on stt_pkg.
module stt_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  stt_pkg::tok_t res_in [stt_pkg::MAX_RES],
    input  logic [2:0]    cnt_in,
    input  logic          out_stall,
    output logic          out_valid,
    output stt_pkg::tok_t tok,
    output logic          last,
    output logic          hold
);

    stt_pkg::tok_t res_reg [stt_pkg::MAX_RES];
    logic [2:0]    rem_reg, rem_next;
    logic [1:0]    idx_reg, idx_next;
    logic          out_take;

    assign out_valid = (rem_reg != 3'd0);
    assign out_take  = out_valid && !out_stall;
    assign tok       = res_reg[idx_reg];
    assign last      = (rem_reg == 3'd1);
    // Stall the source unless the bank is empty or drains its last beat now
    assign hold      = (rem_reg > 3'd1) || ((rem_reg == 3'd1) && out_stall);

    // Count remaining beats and advance the read slot
    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load) begin
            rem_next = cnt_in;
            idx_next = 2'd0;
        end else if (out_take) begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg <= 3'd0;
            idx_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    // Capture the tokens of a new byte
    always_ff @(posedge clk)
    begin
        if (load) begin
            for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
                res_reg[i] <= res_in[i];
            end
        end
    end

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd4)
        else $error("result count out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (rem_reg == 3'd0) || ((rem_reg == 3'd1) && out_take))
        else $error("byte loaded over pending results");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !load) |=> (rem_reg == $past(rem_reg) - 3'd1))
        else $error("drain count slipped");

    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(idx_reg) + 32'(rem_reg) <= 32'd4))
        else $error("read slot beyond loaded results");

endmodule

### test/tb_top.sv
// Self-checking testbench for source_text_tokenizer_core: byte stream in, token beats out.
// A token predictor runs on every accepted byte; results are matched in order.
// Depends on rtl/stt_pkg.sv and rtl/source_text_tokenizer_core.sv.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 190;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        logic [5:0] chk;
    } src_byte_t;

    typedef struct {
        logic [5:0]  kind;
        logic [19:0] start;
        logic [19:0] len;
        logic [19:0] line;
        logic [30:0] ival;
        logic        ovf;
        logic        last;
    } token_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        src_valid = 1'b0;
    logic        src_stall;
    logic [7:0]  ch = '0;
    logic        final_byte = 1'b0;
    logic        tok_valid;
    logic        tok_stall = 1'b1;
    logic [5:0]  kind;
    logic [19:0] start_offset;
    logic [19:0] lexeme_length;
    logic [19:0] line_number;
    logic [30:0] int_value;
    logic        int_overflow;
    logic        last_of_run;

    source_text_tokenizer_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall), .ch(ch), .final_byte(final_byte),
        .tok_valid(tok_valid), .tok_stall(tok_stall), .kind(kind),
        .start_offset(start_offset), .lexeme_length(lexeme_length),
        .line_number(line_number), .int_value(int_value),
        .int_overflow(int_overflow), .last_of_run(last_of_run)
    );

    always #1 clk = ~clk;

    src_byte_t source_bytes[$];
    token_t    pending_tokens[$];
    token_t    byte_tokens[$];
    int        n_accepted = 0;
    int        n_tokens = 0;
    int        n_errors = 0;
    bit        stimulus_done = 0;

    string keyword_text[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
        "or", "print", "return", "super", "this", "true", "var", "while"};

    // Scanner state mirrored from the block
    stt_pkg::mode_t lex_mode;
    logic [19:0]    tok_start;
    logic [19:0]    byte_pos;
    logic [19:0]    line_cnt;
    logic [7:0]     pair_first;
    logic [47:0]    kw_buf;
    logic [30:0]    accum;
    logic           accum_ovf;

    function automatic void clear_scanner();
        lex_mode = stt_pkg::M_IDLE;
        tok_start = '0;
        byte_pos = '0;
        line_cnt = 20'd1;
        pair_first = '0;
        kw_buf = '0;
        accum = '0;
        accum_ovf = 1'b0;
    endfunction

    function automatic void bump_line();
        if (line_cnt != 20'hFFFFF) line_cnt++;
    endfunction

    function automatic void push_token(logic [5:0] k, logic [19:0] s, logic [19:0] l,
                                       logic [30:0] v, logic o);
        token_t t;
        t.kind = k; t.start = s; t.len = l; t.line = line_cnt;
        t.ival = v; t.ovf = o; t.last = 1'b0;
        if (byte_tokens.size() < stt_pkg::MAX_RES) byte_tokens = {byte_tokens, t};
    endfunction

    function automatic bit digit_byte(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alpha_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // One-byte operator kind, K_NONE otherwise
    function automatic logic [5:0] lone_op(logic [7:0] c);
        case (c)
            "(": return stt_pkg::K_LPAREN;
            ")": return stt_pkg::K_RPAREN;
            "{": return stt_pkg::K_LBRACE;
            "}": return stt_pkg::K_RBRACE;
            "[": return stt_pkg::K_LBRACK;
            "]": return stt_pkg::K_RBRACK;
            ",": return stt_pkg::K_COMMA;
            ".": return stt_pkg::K_DOT;
            ";": return stt_pkg::K_SEMI;
            "*": return stt_pkg::K_STAR;
            "^": return stt_pkg::K_CARET;
            "%": return stt_pkg::K_PERCENT;
            8'h5C: return stt_pkg::K_BSLASH;
            default: return stt_pkg::K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] pair_single(logic [7:0] p);
        case (p)
            stt_pkg::C_MINUS: return stt_pkg::K_MINUS;
            stt_pkg::C_PLUS:  return stt_pkg::K_PLUS;
            stt_pkg::C_BANG:  return stt_pkg::K_BANG;
            stt_pkg::C_EQUAL: return stt_pkg::K_EQUAL;
            stt_pkg::C_LESS:  return stt_pkg::K_LESS;
            default:          return stt_pkg::K_GREATER;
        endcase
    endfunction

    function automatic logic [7:0] pair_follow(logic [7:0] p);
        if (p == stt_pkg::C_MINUS || p == stt_pkg::C_PLUS) return p;
        return stt_pkg::C_EQUAL;
    endfunction

    function automatic logic [5:0] word_kind(logic [19:0] len);
        logic [47:0] w;
        if (len > 6) return stt_pkg::K_IDENT;
        for (int i = 0; i < 16; i++) begin
            w = '0;
            for (int j = 0; j < keyword_text[i].len(); j++) w = {w[39:0], keyword_text[i][j]};
            if (w == kw_buf) return stt_pkg::K_KEYWORD0 + 6'(i);
        end
        return stt_pkg::K_IDENT;
    endfunction

    function automatic void open_lexeme(logic [7:0] c, logic [19:0] pos);
        logic [5:0] k;
        k = lone_op(c);
        tok_start = pos;
        lex_mode = stt_pkg::M_IDLE;
        if (k != stt_pkg::K_NONE) begin
            push_token(k, pos, 20'd1, '0, 1'b0);
        end else if (c == stt_pkg::C_MINUS || c == stt_pkg::C_PLUS || c == stt_pkg::C_BANG
                     || c == stt_pkg::C_EQUAL || c == stt_pkg::C_LESS
                     || c == stt_pkg::C_GREAT) begin
            lex_mode = stt_pkg::M_OP2;
            pair_first = c;
        end else if (c == stt_pkg::C_SLASH) begin
            lex_mode = stt_pkg::M_SLASH;
        end else if (c == stt_pkg::C_SPACE || c == stt_pkg::C_NUL || c == stt_pkg::C_CR
                     || c == stt_pkg::C_TAB) begin
        end else if (c == stt_pkg::C_LF) begin
            bump_line();
        end else if (c == stt_pkg::C_QUOTE) begin
            lex_mode = stt_pkg::M_STRING;
        end else if (digit_byte(c)) begin
            lex_mode = stt_pkg::M_INT;
            accum = 31'(c - "0");
            accum_ovf = 1'b0;
        end else if (alpha_byte(c)) begin
            lex_mode = stt_pkg::M_IDENT;
            kw_buf = 48'(c);
        end else begin
            push_token(stt_pkg::K_BADCHAR, pos, 20'd1, '0, 1'b0);
        end
    endfunction

    function automatic void scan(logic [7:0] c, logic [19:0] pos);
        logic [63:0] v;
        case (lex_mode)
            stt_pkg::M_OP2: begin
                lex_mode = stt_pkg::M_IDLE;
                if (c == pair_follow(pair_first)) begin
                    push_token(pair_single(pair_first) + 6'd1, tok_start, 20'd2, '0, 1'b0);
                end else begin
                    push_token(pair_single(pair_first), tok_start, 20'd1, '0, 1'b0);
                    open_lexeme(c, pos);
                end
            end
            stt_pkg::M_SLASH: begin
                if (c == stt_pkg::C_SLASH) lex_mode = stt_pkg::M_LINECMT;
                else if (c == stt_pkg::C_STAR) lex_mode = stt_pkg::M_BLOCK;
                else begin
                    push_token(stt_pkg::K_SLASH, tok_start, 20'd1, '0, 1'b0);
                    open_lexeme(c, pos);
                end
            end
            stt_pkg::M_LINECMT: begin
                if (c == stt_pkg::C_LF) begin
                    lex_mode = stt_pkg::M_IDLE;
                    bump_line();
                end
            end
            stt_pkg::M_BLOCK: begin
                if (c == stt_pkg::C_STAR) lex_mode = stt_pkg::M_BLOCKSTAR;
                else if (c == stt_pkg::C_LF) bump_line();
            end
            stt_pkg::M_BLOCKSTAR: begin
                if (c == stt_pkg::C_SLASH) lex_mode = stt_pkg::M_IDLE;
                else if (c != stt_pkg::C_STAR) begin
                    lex_mode = stt_pkg::M_BLOCK;
                    if (c == stt_pkg::C_LF) bump_line();
                end
            end
            stt_pkg::M_STRING: begin
                if (c == stt_pkg::C_QUOTE) begin
                    push_token(stt_pkg::K_STRING, tok_start, pos + 20'd1 - tok_start,
                               '0, 1'b0);
                    lex_mode = stt_pkg::M_IDLE;
                end else if (c == stt_pkg::C_LF) begin
                    bump_line();
                end
            end
            stt_pkg::M_INT: begin
                if (digit_byte(c)) begin
                    v = 64'(accum) * 10 + 64'(c - "0");
                    if (v > 64'h7FFF_FFFF) begin
                        v = 64'h7FFF_FFFF;
                        accum_ovf = 1'b1;
                    end
                    accum = v[30:0];
                end else if (c == stt_pkg::C_DOT) begin
                    lex_mode = stt_pkg::M_INTDOT;
                end else begin
                    push_token(stt_pkg::K_INTEGER, tok_start, pos - tok_start, accum,
                               accum_ovf);
                    open_lexeme(c, pos);
                end
            end
            stt_pkg::M_INTDOT: begin
                if (digit_byte(c)) begin
                    lex_mode = stt_pkg::M_FRAC;
                end else begin
                    push_token(stt_pkg::K_INTEGER, tok_start, pos - 20'd1 - tok_start, accum,
                               accum_ovf);
                    push_token(stt_pkg::K_DOT, pos - 20'd1, 20'd1, '0, 1'b0);
                    open_lexeme(c, pos);
                end
            end
            stt_pkg::M_FRAC: begin
                if (!digit_byte(c)) begin
                    push_token(stt_pkg::K_DECIMAL, tok_start, pos - tok_start, '0, 1'b0);
                    open_lexeme(c, pos);
                end
            end
            stt_pkg::M_IDENT: begin
                if (alpha_byte(c) || digit_byte(c)) begin
                    kw_buf = {kw_buf[39:0], c};
                end else begin
                    push_token(word_kind(pos - tok_start), tok_start, pos - tok_start, '0, 1'b0);
                    open_lexeme(c, pos);
                end
            end
            default: open_lexeme(c, pos);
        endcase
    endfunction

    // Complete whatever lexeme is open, then the end token
    function automatic void close_source(logic [19:0] fin_pos);
        logic [19:0] len;
        len = fin_pos - tok_start;
        case (lex_mode)
            stt_pkg::M_OP2:
                push_token(pair_single(pair_first), tok_start, 20'd1, '0, 1'b0);
            stt_pkg::M_SLASH:  push_token(stt_pkg::K_SLASH, tok_start, 20'd1, '0, 1'b0);
            stt_pkg::M_STRING: push_token(stt_pkg::K_UNTERM, tok_start, len, '0, 1'b0);
            stt_pkg::M_INT:
                push_token(stt_pkg::K_INTEGER, tok_start, len, accum, accum_ovf);
            stt_pkg::M_INTDOT: begin
                push_token(stt_pkg::K_INTEGER, tok_start, len - 20'd1, accum, accum_ovf);
                push_token(stt_pkg::K_DOT, fin_pos - 20'd1, 20'd1, '0, 1'b0);
            end
            stt_pkg::M_FRAC:   push_token(stt_pkg::K_DECIMAL, tok_start, len, '0, 1'b0);
            stt_pkg::M_IDENT:  push_token(word_kind(len), tok_start, len, '0, 1'b0);
            default: ;
        endcase
        push_token(stt_pkg::K_END, fin_pos, 20'd0, '0, 1'b0);
    endfunction

    function automatic void tokenize_byte(src_byte_t b);
        logic [19:0] pos;
        byte_tokens.delete();
        pos = byte_pos;
        scan(b.ch, pos);
        byte_pos = pos + 20'd1;
        if (b.fin) begin
            close_source(byte_pos);
            clear_scanner();
        end
        if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        if (b.chk != stt_pkg::K_NONE
            && (byte_tokens.size() == 0 || byte_tokens[0].kind != b.chk)) begin
            $error("directed byte %0d: kind expected %0d, predicted otherwise",
                   n_accepted, b.chk);
            n_errors++;
        end
        foreach (byte_tokens[i]) pending_tokens = {pending_tokens, byte_tokens[i]};
    endfunction

    // Stimulus building
    function automatic void add_byte(logic [7:0] c, logic fin = 1'b0,
                                     logic [5:0] chk = stt_pkg::K_NONE);
        src_byte_t b;
        b.ch = c; b.fin = fin; b.chk = chk;
        source_bytes = {source_bytes, b};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_random_token();
        string ops[13] = '{"-", "--", "+", "++", "!", "!=", "=", "==", "<", "<=", ">", ">=",
                           "/"};
        string lone = "(){}[],.;*^%\\";
        string ws = {" ", "\t", "\r", "\n", " "};
        int n;
        case ($urandom_range(0, 13))
            0, 1: add_text(keyword_text[$urandom_range(0, 15)]);
            2: begin
                n = $urandom_range(1, 9);
                add_byte(($urandom_range(0, 1) != 0) ? 8'("a" + $urandom_range(0, 25)) : "_");
                for (int i = 1; i < n; i++)
                    case ($urandom_range(0, 3))
                        0: add_byte(8'("0" + $urandom_range(0, 9)));
                        1: add_byte(8'("A" + $urandom_range(0, 25)));
                        default: add_byte(8'("a" + $urandom_range(0, 25)));
                    endcase
            end
            3: begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
                for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(0, 9)));
                if ($urandom_range(0, 2) == 0) add_byte(".");
            end
            4: begin
                add_byte(8'("0" + $urandom_range(0, 9)));
                add_byte(".");
                for (int i = 0; i < $urandom_range(1, 3); i++)
                    add_byte(8'("0" + $urandom_range(0, 9)));
            end
            5: begin
                add_byte(stt_pkg::C_QUOTE);
                for (int i = 0; i < $urandom_range(0, 4); i++)
                    add_byte(($urandom_range(0, 4) == 0) ? stt_pkg::C_LF
                             : 8'("a" + $urandom_range(0, 25)));
                if ($urandom_range(0, 3) != 0) add_byte(stt_pkg::C_QUOTE);
            end
            6: begin
                add_text("//");
                add_byte(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 3) != 0) add_byte(stt_pkg::C_LF);
            end
            7: begin
                add_text("/*");
                for (int i = 0; i < $urandom_range(0, 4); i++)
                    case ($urandom_range(0, 3))
                        0: add_byte(stt_pkg::C_STAR);
                        1: add_byte(stt_pkg::C_LF);
                        default: add_byte(8'("a" + $urandom_range(0, 25)));
                    endcase
                if ($urandom_range(0, 3) != 0) add_text("*/");
            end
            8: add_text(ops[$urandom_range(0, 12)]);
            9: add_byte(lone[$urandom_range(0, lone.len() - 1)]);
            10: add_byte(ws[$urandom_range(0, ws.len() - 1)]);
            11: add_byte(stt_pkg::C_NUL);
            default: add_byte(8'($urandom_range(0, 255)));
        endcase
    endfunction

    task automatic build_stimulus();
        int stop;
        // Directed: every one-byte operator but the dot, bad bytes, pair operators,
        // integer-dot-letter, and a source that ends inside a string
        add_byte("(", 1'b0, stt_pkg::K_LPAREN);
        add_byte(")", 1'b0, stt_pkg::K_RPAREN);
        add_byte("{", 1'b0, stt_pkg::K_LBRACE);
        add_byte("}", 1'b0, stt_pkg::K_RBRACE);
        add_byte("[", 1'b0, stt_pkg::K_LBRACK);
        add_byte("]", 1'b0, stt_pkg::K_RBRACK);
        add_byte(",", 1'b0, stt_pkg::K_COMMA);
        add_byte(";", 1'b0, stt_pkg::K_SEMI);
        add_byte("*", 1'b0, stt_pkg::K_STAR);
        add_byte("^", 1'b0, stt_pkg::K_CARET);
        add_byte("%", 1'b0, stt_pkg::K_PERCENT);
        add_byte(8'h5C, 1'b0, stt_pkg::K_BSLASH);
        add_byte("@", 1'b0, stt_pkg::K_BADCHAR);
        add_byte(8'hFF, 1'b0, stt_pkg::K_BADCHAR);
        add_text("--<=\n9.x");
        add_byte(stt_pkg::C_QUOTE);
        add_byte("a", 1'b1);
        // Directed: end inside a comment and after a pending operator
        add_text("/*");
        add_byte(stt_pkg::C_LF, 1'b1, stt_pkg::K_END);
        add_byte(stt_pkg::C_GREAT, 1'b1, stt_pkg::K_GREATER);
        // Random sources of well-formed tokens with noise mixed in
        stop = source_bytes.size() + RANDOM_BYTES;
        while (source_bytes.size() < stop) begin
            for (int t = $urandom_range(2, 14); t > 0; t--) begin
                add_random_token();
                if ($urandom_range(0, 2) != 0) add_byte(stt_pkg::C_SPACE);
            end
            source_bytes[source_bytes.size() - 1].fin = 1'b1;
        end
    endtask

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Reset and byte sender
    initial begin
        bit calm;
        build_stimulus();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (source_bytes[i]) begin
            int gap;
            if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = draw_wait(calm);
            if (gap > 0) begin
                src_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            src_valid <= 1'b1;
            ch <= source_bytes[i].ch;
            final_byte <= source_bytes[i].fin;
            do @(posedge clk); while (src_stall);
        end
        src_valid <= 1'b0;
        stimulus_done = 1;
    end

    // Token receiver; one long hold-off fills the block
    initial begin
        bit calm;
        int hold;
        int n_taken;
        n_taken = 0;
        @(posedge rst_n);
        forever begin
            if (n_taken % 30 == 0) calm = ($urandom_range(0, 3) == 0);
            hold = (n_taken == 40) ? HOLD_CYCLES : draw_wait(calm);
            if (hold > 0) begin
                tok_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            tok_stall <= 1'b0;
            do @(posedge clk); while (!tok_valid);
            n_taken++;
        end
    end

    // Predict on each accepted byte beat
    initial clear_scanner();
    always @(posedge clk) begin
        if (rst_n && src_valid && !src_stall) begin
            tokenize_byte(source_bytes[n_accepted]);
            n_accepted++;
        end
    end

    // Compare each accepted token beat with the oldest prediction
    always @(posedge clk) begin
        token_t e;
        if (rst_n && tok_valid && !tok_stall) begin
            n_tokens++;
            if (pending_tokens.size() == 0) begin
                $error("token beat %0d with nothing expected", n_tokens);
                n_errors++;
            end else begin
                e = pending_tokens.pop_front();
                if (kind !== e.kind) begin
                    $error("kind: expected %0d, actual %0d", e.kind, kind);
                    n_errors++;
                end
                if (start_offset !== e.start) begin
                    $error("start_offset: expected %0d, actual %0d", e.start, start_offset);
                    n_errors++;
                end
                if (lexeme_length !== e.len) begin
                    $error("lexeme_length: expected %0d, actual %0d", e.len, lexeme_length);
                    n_errors++;
                end
                if (line_number !== e.line) begin
                    $error("line_number: expected %0d, actual %0d", e.line, line_number);
                    n_errors++;
                end
                if (int_value !== e.ival) begin
                    $error("int_value: expected %0d, actual %0d", e.ival, int_value);
                    n_errors++;
                end
                if (int_overflow !== e.ovf) begin
                    $error("int_overflow: expected %0d, actual %0d", e.ovf, int_overflow);
                    n_errors++;
                end
                if (last_of_run !== e.last) begin
                    $error("last_of_run: expected %0d, actual %0d", e.last, last_of_run);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: cycles with no beat on either side
    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((src_valid && !src_stall) || (tok_valid && !tok_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("source_text_tokenizer_core regression: fail");
            $finish;
        end
    end

    // Drain, settle, report; let the last byte be predicted before checking the drain
    initial begin
        wait (stimulus_done);
        @(posedge clk);
        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_errors == 0) begin
            $display("source_text_tokenizer_core regression: pass");
        end else begin
            $display("source_text_tokenizer_core regression: fail");
        end
        $finish;
    end

endmodule
